FILE: rtl/ehwf_pkg.sv
package ehwf_pkg;

   // Frame and window geometry.
   localparam int IMAGE_WIDTH  = 512;
   localparam int IMAGE_HEIGHT = 512;
   localparam int KERNEL_SIZE  = 3;
   localparam int HALF_K       = KERNEL_SIZE / 2;

   // Pixel format and thresholds.
   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] STRONG_MASK = 8'hC0;
   localparam logic [PIX_W-1:0] PIX_MAX     = 8'hFF;

   // Counter widths.
   localparam int COL_W        = $clog2(IMAGE_WIDTH);
   localparam int ROW_W        = $clog2(IMAGE_HEIGHT);
   localparam int PRIME_TARGET = IMAGE_WIDTH * HALF_K + HALF_K;
   localparam int PRIME_W      = $clog2(PRIME_TARGET + 1);

   // The line store keeps KERNEL_SIZE-1 rows side by side in one word per column.
   localparam int STORE_W = (KERNEL_SIZE - 1) * PIX_W;

   typedef logic [PIX_W-1:0] pixel_type;

   // One window column; element 0 is the oldest row, element KERNEL_SIZE-1 the newest.
   typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] column_type;

   // True when any pixel of the column has one of its top two bits set.
   function automatic logic column_strong(column_type col);
      logic hit;
      hit = 1'b0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         hit = hit | ((col[r] & STRONG_MASK) != '0);
      end
      return hit;
   endfunction

endpackage

FILE: rtl/ehwf_req_if.sv
interface ehwf_req_if;
   logic                       valid;
   logic                       ready;
   logic [ehwf_pkg::PIX_W-1:0] pixel_in;
   logic                       filter_on;

   modport source (output valid, output pixel_in, output filter_on, input ready);
   modport sink   (input valid, input pixel_in, input filter_on, output ready);
endinterface

FILE: rtl/ehwf_rsp_if.sv
interface ehwf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ehwf_pkg::PIX_W-1:0] pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface

FILE: rtl/ehwf_ram.sv
module ehwf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ehwf_cell.sv
module ehwf_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  ehwf_pkg::column_type column_from,
   output ehwf_pkg::column_type column_out,
   output logic                 has_strong
);

   ehwf_pkg::column_type column_ff;
   ehwf_pkg::column_type column_in;

   // Take the neighbouring column whenever an item moves the window.
   assign column_in = shift ? column_from : column_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else begin
         column_ff <= column_in;
      end
   end

   assign column_out = column_ff;
   assign has_strong = ehwf_pkg::column_strong(column_ff);

endmodule

FILE: rtl/edge_hysteresis_window_filter.sv
// Edge hysteresis window filter. One 8-bit pixel is taken per clock in raster order unless
// the output is stalled, and its result appears in the output register on the following
// cycle; a stalled output holds only one item and the input keeps accepting while that
// item is being taken. After reset the first IMAGE_WIDTH*(KERNEL_SIZE/2)+KERNEL_SIZE/2
// items (513 for a 512-wide frame with a 3x3 window) only fill the window and give no
// result; from then on every item gives exactly one. The line store is a single RAM of
// IMAGE_WIDTH words holding KERNEL_SIZE-1 rows per word, which is read one column ahead
// and written once per item. It needs no clearing pass: until the store column pointer
// first wraps, its contents read as zero. The window is a row of KERNEL_SIZE column
// cells that shift one place per item; frames follow back to back and border positions
// are blanked when the filter is on.
module edge_hysteresis_window_filter (
   input  logic              clock,
   input  logic              reset,
   ehwf_req_if.sink          req_chan,
   ehwf_rsp_if.source        rsp_chan
);

   logic accept;
   logic primed;
   logic emit;

   logic [ehwf_pkg::COL_W-1:0]   store_col_ff, store_col_in;
   logic                         filled_ff, filled_in;
   logic [ehwf_pkg::PRIME_W-1:0] prime_count_ff, prime_count_in;
   logic [ehwf_pkg::ROW_W-1:0]   centre_row_ff, centre_row_in;
   logic [ehwf_pkg::COL_W-1:0]   centre_col_ff, centre_col_in;

   logic [ehwf_pkg::STORE_W-1:0] store_rd;
   logic [ehwf_pkg::STORE_W-1:0] store_rows;
   ehwf_pkg::column_type         new_col;

   ehwf_pkg::column_type         cell_out [ehwf_pkg::KERNEL_SIZE];
   logic [ehwf_pkg::KERNEL_SIZE-1:0] cell_strong;

   ehwf_pkg::pixel_type          centre;
   ehwf_pkg::pixel_type          doubled;
   ehwf_pkg::pixel_type          result;
   logic                         any_strong;
   logic                         border;

   logic                         rsp_valid_ff, rsp_valid_in;
   ehwf_pkg::pixel_type          rsp_pixel_ff, rsp_pixel_in;

   // Handshake: the output register frees up in the same cycle it is taken.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign primed         = prime_count_ff == ehwf_pkg::PRIME_W'(ehwf_pkg::PRIME_TARGET);
   assign emit           = accept && primed;

   // Line store pointer and first-pass flag.
   always_comb begin
      store_col_in = store_col_ff;
      filled_in    = filled_ff;
      if (accept) begin
         if (store_col_ff == ehwf_pkg::COL_W'(ehwf_pkg::IMAGE_WIDTH - 1)) begin
            store_col_in = '0;
            filled_in    = 1'b1;
         end else begin
            store_col_in = store_col_ff + ehwf_pkg::COL_W'(1);
         end
      end
   end

   // The read address runs on the next pointer, so the read data always matches the
   // column the next item will use.
   ehwf_ram #(
      .WIDTH (ehwf_pkg::STORE_W),
      .DEPTH (ehwf_pkg::IMAGE_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (store_col_ff),
      .wr_data (new_col[ehwf_pkg::KERNEL_SIZE-1:1]),
      .rd_addr (store_col_in),
      .rd_data (store_rd)
   );

   assign store_rows = filled_ff ? store_rd : '0;
   assign new_col    = {req_chan.pixel_in, store_rows};

   // Window: the last cell takes the new column, each other cell takes its right neighbour.
   for (genvar k = 0; k < ehwf_pkg::KERNEL_SIZE; k++) begin : g_cell
      if (k == ehwf_pkg::KERNEL_SIZE - 1) begin : g_head
         ehwf_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (accept),
            .column_from (new_col),
            .column_out  (cell_out[k]),
            .has_strong  (cell_strong[k])
         );
      end else begin : g_body
         ehwf_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (accept),
            .column_from (cell_out[k+1]),
            .column_out  (cell_out[k]),
            .has_strong  (cell_strong[k])
         );
      end
   end

   // Result for the window as it stands after this item has shifted in.
   assign centre     = cell_out[ehwf_pkg::HALF_K + 1][ehwf_pkg::HALF_K];
   assign any_strong = (|cell_strong[ehwf_pkg::KERNEL_SIZE-1:1]) ||
                       ehwf_pkg::column_strong(new_col);
   assign doubled = centre[ehwf_pkg::PIX_W-1] ? ehwf_pkg::PIX_MAX
                                              : {centre[ehwf_pkg::PIX_W-2:0], 1'b0};
   assign border  = (centre_row_ff < ehwf_pkg::ROW_W'(ehwf_pkg::HALF_K)) ||
                    (centre_row_ff >=
                        ehwf_pkg::ROW_W'(ehwf_pkg::IMAGE_HEIGHT - ehwf_pkg::HALF_K)) ||
                    (centre_col_ff < ehwf_pkg::COL_W'(ehwf_pkg::HALF_K)) ||
                    (centre_col_ff >=
                        ehwf_pkg::COL_W'(ehwf_pkg::IMAGE_WIDTH - ehwf_pkg::HALF_K));

   always_comb begin
      if (!req_chan.filter_on) begin
         result = centre;
      end else if (border || !any_strong) begin
         result = '0;
      end else begin
         result = doubled;
      end
   end

   // Priming count and centre position.
   always_comb begin
      prime_count_in = prime_count_ff;
      centre_row_in  = centre_row_ff;
      centre_col_in  = centre_col_ff;
      if (accept && !primed) begin
         prime_count_in = prime_count_ff + ehwf_pkg::PRIME_W'(1);
      end
      if (emit) begin
         if (centre_col_ff == ehwf_pkg::COL_W'(ehwf_pkg::IMAGE_WIDTH - 1)) begin
            centre_col_in = '0;
            if (centre_row_ff == ehwf_pkg::ROW_W'(ehwf_pkg::IMAGE_HEIGHT - 1)) begin
               centre_row_in = '0;
            end else begin
               centre_row_in = centre_row_ff + ehwf_pkg::ROW_W'(1);
            end
         end else begin
            centre_col_in = centre_col_ff + ehwf_pkg::COL_W'(1);
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pixel_in = rsp_pixel_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_col_ff   <= '0;
         filled_ff      <= 1'b0;
         prime_count_ff <= '0;
         centre_row_ff  <= '0;
         centre_col_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         store_col_ff   <= store_col_in;
         filled_ff      <= filled_in;
         prime_count_ff <= prime_count_in;
         centre_row_ff  <= centre_row_in;
         centre_col_ff  <= centre_col_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pixel_out = rsp_pixel_ff;

   // A result is only ever held once the window has been primed.
   a_no_result_while_priming : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff |-> primed
   ) else $error("result present before the window was primed");

   // Every item accepted after priming lands in the output register.
   a_emit_lands : assert property (
      @(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff
   ) else $error("accepted item produced no result");

   // The centre position does not move while the window is still priming.
   a_position_holds : assert property (
      @(posedge clock) disable iff (reset)
      (accept && !primed) |=> ($stable(centre_col_ff) && $stable(centre_row_ff))
   ) else $error("centre position advanced during priming");

   // The first-pass flag is set only by a wrap of the store pointer.
   a_fill_on_wrap : assert property (
      @(posedge clock) disable iff (reset)
      $rose(filled_ff) |-> (store_col_ff == '0)
   ) else $error("line store marked filled without a pointer wrap");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ehwf_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 280;
   localparam int BAND_COUNT      = 16;
   localparam int BAND_W          = IMAGE_WIDTH / BAND_COUNT;

   // Kinds of content given to a band of columns, so that whole windows can be weak.
   typedef enum int {
      BAND_WEAK,
      BAND_ANY,
      BAND_MID,
      BAND_BRIGHT,
      BAND_SPARSE
   } band_kind_type;

   logic clock;
   logic reset;

   ehwf_req_if req_chan ();
   ehwf_rsp_if rsp_chan ();

   edge_hysteresis_window_filter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Traffic shaping, shared by the stimulus and the result side.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_left      = 0;
   int error_count        = 0;

   pixel_type     expected_pixels [$];
   band_kind_type band_mode [BAND_COUNT];

   // Own copy of the filter state: line store, window and raster position.
   pixel_type   line_rows [KERNEL_SIZE-1][IMAGE_WIDTH];
   pixel_type   window_px [KERNEL_SIZE][KERNEL_SIZE];
   int unsigned line_col    = 0;
   int unsigned fill_count  = 0;
   int unsigned centre_row  = 0;
   int unsigned centre_col  = 0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Shifts one accepted pixel into the window and queues the centre result, if any.
   function automatic void predict_pixel(pixel_type px, logic on);
      pixel_type   column [KERNEL_SIZE];
      pixel_type   centre;
      logic        on_border;
      logic        any_strong;
      int unsigned doubled;
      for (int r = 0; r < KERNEL_SIZE - 1; r++) begin
         column[r] = line_rows[r][line_col];
      end
      column[KERNEL_SIZE-1] = px;
      for (int r = 0; r < KERNEL_SIZE - 2; r++) begin
         line_rows[r][line_col] = line_rows[r+1][line_col];
      end
      line_rows[KERNEL_SIZE-2][line_col] = px;
      line_col = (line_col + 1 >= IMAGE_WIDTH) ? 0 : line_col + 1;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
            window_px[r][k] = window_px[r][k+1];
         end
         window_px[r][KERNEL_SIZE-1] = column[r];
      end

      // While the window fills, nothing comes out.
      if (fill_count != PRIME_TARGET) begin
         fill_count++;
         return;
      end

      on_border = (centre_row < HALF_K) || (centre_row >= IMAGE_HEIGHT - HALF_K) ||
                  (centre_col < HALF_K) || (centre_col >= IMAGE_WIDTH - HALF_K);
      centre_col++;
      if (centre_col >= IMAGE_WIDTH) begin
         centre_col = 0;
         centre_row++;
         if (centre_row >= IMAGE_HEIGHT) begin
            centre_row = 0;
         end
      end

      centre = window_px[HALF_K][HALF_K];
      if (!on) begin
         expected_pixels.push_back(centre);
      end else if (on_border) begin
         expected_pixels.push_back('0);
      end else begin
         any_strong = 1'b0;
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int k = 0; k < KERNEL_SIZE; k++) begin
               if ((window_px[r][k] & STRONG_MASK) != '0) begin
                  any_strong = 1'b1;
               end
            end
         end
         doubled = 2 * centre;
         if (doubled > PIX_MAX) begin
            doubled = PIX_MAX;
         end
         expected_pixels.push_back(any_strong ? pixel_type'(doubled) : pixel_type'(0));
      end
   endfunction

   // Values at the edges of the strong threshold and of the pixel range.
   function automatic pixel_type extreme_pixel(int i);
      case (i % 10)
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h3F;
         3:       return 8'h40;
         4:       return 8'h7F;
         5:       return 8'h80;
         6:       return 8'hBF;
         7:       return 8'hC0;
         8:       return 8'h01;
         default: return 8'hFE;
      endcase
   endfunction

   // Picks a pixel for the next raster column according to the kind of its band.
   function automatic pixel_type pick_pixel();
      case (band_mode[line_col / BAND_W])
         BAND_WEAK:   return pixel_type'($urandom_range(63));
         BAND_MID:    return pixel_type'($urandom_range(127, 64));
         BAND_BRIGHT: return pixel_type'($urandom_range(255, 128));
         BAND_SPARSE: begin
            if ($urandom_range(15) == 0) begin
               return pixel_type'($urandom_range(255, 192));
            end
            return pixel_type'($urandom_range(63));
         end
         default:     return pixel_type'($urandom);
      endcase
   endfunction

   task automatic shuffle_bands();
      for (int b = 0; b < BAND_COUNT; b++) begin
         band_mode[b] = band_kind_type'($urandom_range(BAND_SPARSE));
      end
   endtask

   // Offers one item after a random gap and waits until it is taken.
   task automatic send_pixel(input pixel_type px, input logic on);
      int gap;
      gap = 0;
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.pixel_in  <= px;
      req_chan.filter_on <= on;
      do @(posedge clock); while (!req_chan.ready);
      predict_pixel(px, on);
   endtask

   // Stops offering and waits until every expected result has been taken.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < items; i++) begin
         send_pixel(pick_pixel(), $urandom_range(3) != 0);
      end
   endtask

   // The first items only fill the window; none of them may give a result.
   task automatic test_priming();
      for (int i = 0; i < PRIME_TARGET; i++) begin
         send_pixel(extreme_pixel(i), i[0]);
      end
   endtask

   // The centre sits on the top row: blanked when filtering, passed when not.
   task automatic test_top_border();
      for (int i = 0; i < 24; i++) begin
         send_pixel(extreme_pixel(i + 3), i[0]);
      end
   endtask

   task automatic test_random_traffic();
      shuffle_bands();
      run_phase(PHASE_ITEMS, 0, 0);
      run_phase(PHASE_ITEMS, 48, 0);
      run_phase(PHASE_ITEMS, 0, 48);
      shuffle_bands();
      run_phase(PHASE_ITEMS, 33, 33);
   endtask

   // The receiver holds off for a long stretch while items keep being offered.
   task automatic test_output_hold_off();
      wait_for_drain();
      hold_off_left = HOLD_OFF_CYCLES;
      run_phase(40, 0, 0);
   endtask

   // The sender stops until every result is back, then carries on.
   task automatic test_drain_pause();
      run_phase(30, 33, 33);
      wait_for_drain();
      run_phase(30, 33, 33);
   endtask

   // Result side: checks each accepted item, then chooses ready for the next cycle.
   initial begin : rsp_side
      pixel_type want;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %0d",
                        $time, rsp_chan.pixel_out);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_chan.pixel_out !== want) begin
                  $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                           $time, want, rsp_chan.pixel_out);
                  error_count++;
               end
            end
         end
         if (hold_off_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Test sequence.
   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.pixel_in  <= '0;
      req_chan.filter_on <= 1'b0;
      for (int r = 0; r < KERNEL_SIZE - 1; r++) begin
         for (int c = 0; c < IMAGE_WIDTH; c++) begin
            line_rows[r][c] = '0;
         end
      end
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int k = 0; k < KERNEL_SIZE; k++) begin
            window_px[r][k] = '0;
         end
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_priming();
      test_top_border();
      test_random_traffic();
      test_output_hold_off();
      test_drain_pause();

      receiver_stall_pct = 0;
      wait_for_drain();
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("** edge_hysteresis_window_filter: PASSED **");
      end else begin
         $display("** edge_hysteresis_window_filter: FAILED **");
      end
      $finish;
   end

   // Guard against a hang: well beyond the slowest correct run.
   initial begin
      #3000000;
      $display("** edge_hysteresis_window_filter: FAILED **");
      $finish;
   end

endmodule
